FILE: hdl/u8l_pkg.sv
package u8l_pkg;

	localparam int unsigned RunBytes = 4;
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueueAw = $clog2(QueueDepth);

	// Byte-class marks and case offsets
	localparam logic [7:0] ContMark = 8'h80;
	localparam logic [20:0] CaseOffset = 21'h000020;
	localparam logic [20:0] CyrOffset = 21'h000050;
	localparam logic [20:0] MaxCodePoint = 21'h10FFFF;

	// One run of result bytes caused by a single input item
	typedef struct packed {
		logic [RunBytes-1:0][7:0] data;
		logic [RunBytes-1:0] unm;
		logic [RunBytes-1:0] mal;
		logic [1:0] cnt_m1;
		logic eot;
	} run_t;

	typedef struct packed {
		logic full;
	} push_ctl_t;

	typedef struct packed {
		logic pop;
	} pop_ctl_t;

endpackage

FILE: hdl/u8l_in_if.sv
interface u8l_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;
	logic end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

FILE: hdl/u8l_out_if.sv
interface u8l_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic run_last;
	logic text_last;
	logic unmapped;
	logic malformed;

	modport source (output valid, output out_byte, output run_last, output text_last,
		output unmapped, output malformed, input ready);
	modport sink (input valid, input out_byte, input run_last, input text_last,
		input unmapped, input malformed, output ready);
endinterface

FILE: hdl/u8l_front.sv
module u8l_front (
	input logic clk,
	input logic arst_n,
	u8l_in_if.sink byte_stream,
	output u8l_pkg::run_t rec,
	output logic push,
	input logic full
);

	logic [23:0] held_q, held_d;
	logic [1:0] exp_q, exp_d;
	logic [1:0] seen_q, seen_d;
	logic [20:0] cps_q, cps_d;

	logic [7:0] b;
	logic eot;
	logic accept;
	logic [20:0] c;
	logic [31:0] word;
	logic [20:0] min_cp;
	logic bad;
	logic [21:0] lm;
	logic [31:0] enc_word;
	logic [2:0] enc_len;

	logic [31:0] pk_word;
	logic [2:0] pk_len;
	logic pk_unm, pk_mal;
	logic sb_en, sb_out, sb_mal;
	logic [7:0] sb_byte;
	logic [31:0] aligned;
	logic [2:0] n;

	function automatic logic [21:0] lower_map(input logic [20:0] cp);
		logic hit;
		logic [20:0] r;
		hit = 1'b1;
		r = cp;
		if ((cp >= 21'h00C0 && cp <= 21'h00D6) || (cp >= 21'h00D8 && cp <= 21'h00DE))
			r = cp + u8l_pkg::CaseOffset;
		else if ((cp >= 21'h00E0 && cp <= 21'h00F6) || (cp >= 21'h00F8 && cp <= 21'h00FE))
			r = cp;
		else if (cp == 21'h0178)
			r = 21'h00FF;
		else if (cp == 21'h00FF)
			r = cp;
		else if (cp == 21'h1E9E)
			r = 21'h00DF;
		else if (cp == 21'h00DF)
			r = cp;
		else if ((cp >= 21'h0100 && cp <= 21'h012F) || (cp >= 21'h0132 && cp <= 21'h0137)
			|| (cp >= 21'h014A && cp <= 21'h0177))
			r = cp[0] ? cp : cp + 21'd1;
		else if ((cp >= 21'h0139 && cp <= 21'h0148) || (cp >= 21'h0179 && cp <= 21'h017E))
			r = cp[0] ? cp + 21'd1 : cp;
		else if (cp == 21'h017F)
			r = cp;
		else if ((cp >= 21'h0391 && cp <= 21'h03A1) || (cp >= 21'h03A3 && cp <= 21'h03AB))
			r = cp + u8l_pkg::CaseOffset;
		else if (cp >= 21'h03B1 && cp <= 21'h03CB)
			r = cp;
		else if (cp == 21'h0401)
			r = 21'h0451;
		else if (cp == 21'h0451)
			r = cp;
		else if (cp >= 21'h0402 && cp <= 21'h040F)
			r = cp + u8l_pkg::CyrOffset;
		else if (cp >= 21'h0452 && cp <= 21'h045F)
			r = cp;
		else if (cp >= 21'h0410 && cp <= 21'h042F)
			r = cp + u8l_pkg::CaseOffset;
		else if (cp >= 21'h0430 && cp <= 21'h044F)
			r = cp;
		else
			hit = 1'b0;
		return {hit, r};
	endfunction

	assign b = byte_stream.in_byte;
	assign eot = byte_stream.end_of_text;
	assign byte_stream.ready = !full;
	assign accept = byte_stream.valid && !full;

	assign c = {cps_q[14:0], b[5:0]};
	assign word = {held_q, b};

	always_comb begin
		case (exp_q)
			2'd1: min_cp = 21'h000080;
			2'd2: min_cp = 21'h000800;
			2'd3: min_cp = 21'h010000;
			default: min_cp = 21'h000000;
		endcase
	end

	assign bad = (c < min_cp) || (c > u8l_pkg::MaxCodePoint)
		|| (c >= 21'h00D800 && c <= 21'h00DFFF);
	assign lm = lower_map(c);

	// Re-encode the lowered code point, right-aligned
	always_comb begin
		if (lm[20:0] < 21'h80) begin
			enc_word = {25'd0, lm[6:0]};
			enc_len = 3'd1;
		end else if (lm[20:0] < 21'h800) begin
			enc_word = {16'd0, 3'b110, lm[10:6], 2'b10, lm[5:0]};
			enc_len = 3'd2;
		end else begin
			enc_word = {8'd0, 4'hE, lm[15:12], 2'b10, lm[11:6], 2'b10, lm[5:0]};
			enc_len = 3'd3;
		end
	end

	always_comb begin
		held_d = held_q;
		exp_d = exp_q;
		seen_d = seen_q;
		cps_d = cps_q;
		pk_word = 32'd0;
		pk_len = 3'd0;
		pk_unm = 1'b0;
		pk_mal = 1'b0;
		sb_en = 1'b0;
		sb_out = 1'b0;
		sb_mal = 1'b0;
		sb_byte = b;

		if (exp_q != 2'd0) begin
			if ((b & 8'hC0) == u8l_pkg::ContMark) begin
				if ({1'b0, seen_q} + 3'd1 >= {1'b0, exp_q}) begin
					if (bad) begin
						pk_word = word;
						pk_len = {1'b0, exp_q} + 3'd1;
						pk_mal = 1'b1;
					end else if (lm[21]) begin
						pk_word = enc_word;
						pk_len = enc_len;
					end else begin
						pk_word = word;
						pk_len = {1'b0, exp_q} + 3'd1;
						pk_unm = 1'b1;
					end
					held_d = 24'd0;
					exp_d = 2'd0;
					seen_d = 2'd0;
					cps_d = 21'd0;
				end else begin
					held_d = word[23:0];
					seen_d = seen_q + 2'd1;
					cps_d = c;
					if (eot) begin
						pk_word = {8'd0, word[23:0]};
						pk_len = {1'b0, seen_q} + 3'd2;
						pk_mal = 1'b1;
					end
				end
			end else begin
				// interrupted sequence: flush held bytes, then restart on this byte
				pk_word = {8'd0, held_q};
				pk_len = {1'b0, seen_q} + 3'd1;
				pk_mal = 1'b1;
				held_d = 24'd0;
				exp_d = 2'd0;
				seen_d = 2'd0;
				cps_d = 21'd0;
				sb_en = 1'b1;
			end
		end else begin
			sb_en = 1'b1;
		end

		if (sb_en) begin
			if (!b[7]) begin
				sb_out = 1'b1;
				sb_byte = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
			end else if (b >= 8'hC2 && b <= 8'hF4) begin
				held_d = {16'd0, b};
				seen_d = 2'd0;
				if (b <= 8'hDF) begin
					exp_d = 2'd1;
					cps_d = {16'd0, b[4:0]};
				end else if (b <= 8'hEF) begin
					exp_d = 2'd2;
					cps_d = {17'd0, b[3:0]};
				end else begin
					exp_d = 2'd3;
					cps_d = {18'd0, b[2:0]};
				end
				// lead byte on the last item is a truncated sequence
				sb_out = eot;
				sb_mal = 1'b1;
			end else begin
				sb_out = 1'b1;
				sb_mal = 1'b1;
			end
		end

		if (eot) begin
			held_d = 24'd0;
			exp_d = 2'd0;
			seen_d = 2'd0;
			cps_d = 21'd0;
		end
	end

	assign aligned = pk_word << {3'd4 - pk_len, 3'b000};
	assign n = pk_len + {2'd0, sb_out};

	always_comb begin
		for (int i = 0; i < u8l_pkg::RunBytes; i++) begin
			rec.data[i] = aligned[31-8*i -: 8];
			rec.unm[i] = (3'(i) < pk_len) && pk_unm;
			rec.mal[i] = (3'(i) < pk_len) && pk_mal;
		end
		if (sb_out) begin
			rec.data[pk_len[1:0]] = sb_byte;
			rec.unm[pk_len[1:0]] = 1'b0;
			rec.mal[pk_len[1:0]] = sb_mal;
		end
		rec.cnt_m1 = 2'(n - 3'd1);
		rec.eot = eot;
	end

	// Items that only extend an open sequence make no run
	assign push = accept && (n != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 24'd0;
			exp_q <= 2'd0;
			seen_q <= 2'd0;
			cps_q <= 21'd0;
		end else if (accept) begin
			held_q <= held_d;
			exp_q <= exp_d;
			seen_q <= seen_d;
			cps_q <= cps_d;
		end
	end

endmodule

FILE: hdl/u8l_queue.sv
module u8l_queue (
	input logic clk,
	input logic arst_n,
	input u8l_pkg::run_t wr_rec,
	output u8l_pkg::push_ctl_t wr_ctl,
	input logic push,
	input logic pop,
	output u8l_pkg::run_t head,
	output logic empty
);

	u8l_pkg::run_t mem_q [u8l_pkg::QueueDepth];
	logic [u8l_pkg::QueueAw-1:0] wp_q, rp_q;
	logic [u8l_pkg::QueueAw:0] cnt_q;
	logic do_push, do_pop;

	assign wr_ctl.full = (cnt_q == (u8l_pkg::QueueAw+1)'(u8l_pkg::QueueDepth));
	assign empty = (cnt_q == '0);
	assign do_push = push && !wr_ctl.full;
	assign do_pop = pop && !empty;
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wp_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= wp_q + 1'b1;
			if (do_pop)
				rp_q <= rp_q + 1'b1;
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hdl/u8l_back.sv
module u8l_back (
	input logic clk,
	input logic arst_n,
	input u8l_pkg::run_t head,
	output u8l_pkg::pop_ctl_t rd_ctl,
	input logic empty,
	u8l_out_if.source lower_stream
);

	logic [1:0] idx_q;
	logic ov_q;
	logic [7:0] byte_q;
	logic run_last_q, text_last_q, unm_q, mal_q;
	logic ld, last;

	assign ld = !empty && (!ov_q || lower_stream.ready);
	assign last = (idx_q == head.cnt_m1);
	assign rd_ctl.pop = ld && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
			ov_q <= 1'b0;
		end else begin
			if (ld) begin
				ov_q <= 1'b1;
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end else if (lower_stream.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Payload of the output register
	always_ff @(posedge clk) begin
		if (ld) begin
			byte_q <= head.data[idx_q];
			unm_q <= head.unm[idx_q];
			mal_q <= head.mal[idx_q];
			run_last_q <= last;
			text_last_q <= last && head.eot;
		end
	end

	assign lower_stream.valid = ov_q;
	assign lower_stream.out_byte = byte_q;
	assign lower_stream.run_last = run_last_q;
	assign lower_stream.text_last = text_last_q;
	assign lower_stream.unmapped = unm_q;
	assign lower_stream.malformed = mal_q;

endmodule

FILE: hdl/utf8_stream_lowercase.sv
// Streaming UTF-8 lowercaser. Each input item is one byte of text; end_of_text marks the
// last byte of a string. ASCII is lowercased at once; multi-byte sequences are held until
// complete, decoded, lowercased for Latin-1, Latin Extended-A, capital sharp s, Greek and
// Cyrillic, and re-encoded. Characters outside those tables pass unchanged with unmapped
// set; invalid, overlong, surrogate or truncated sequences pass raw with malformed set.
// Each item yields 0 to 4 result bytes; run_last marks the last result of an item and
// text_last the last result of a string. The decoder takes one byte per cycle while the
// queue is not full and hands each item's results as one run into a four-entry queue; the
// output serializer then sends one result byte per cycle while the sink is ready, so an
// item producing k bytes holds the output while all k are sent, and sustained throughput
// is one result byte per cycle. Items that only extend an open sequence produce no run.
// An accepted byte's first result is written into the queue, then the output register.
module utf8_stream_lowercase (
	input logic clk,
	input logic arst_n,
	u8l_in_if.sink byte_stream,
	u8l_out_if.source lower_stream
);

	u8l_pkg::run_t wr_rec, head;
	u8l_pkg::push_ctl_t wr_ctl;
	u8l_pkg::pop_ctl_t rd_ctl;
	logic push, empty;

	u8l_front u_front (
		.clk (clk),
		.arst_n (arst_n),
		.byte_stream (byte_stream),
		.rec (wr_rec),
		.push (push),
		.full (wr_ctl.full)
	);

	u8l_queue u_queue (
		.clk (clk),
		.arst_n (arst_n),
		.wr_rec (wr_rec),
		.wr_ctl (wr_ctl),
		.push (push),
		.pop (rd_ctl.pop),
		.head (head),
		.empty (empty)
	);

	u8l_back u_back (
		.clk (clk),
		.arst_n (arst_n),
		.head (head),
		.rd_ctl (rd_ctl),
		.empty (empty),
		.lower_stream (lower_stream)
	);

endmodule
